/* design/spm_pkg.sv */
// ----------------------------------------------------------------------------
// spm_pkg
// shared types and codes for the sample playback mixer
// ----------------------------------------------------------------------------
package spm_pkg;

    // request codes carried on req_type
    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_LEN   = 3'd1;
    localparam logic [2:0] REQ_SPEED = 3'd2;
    localparam logic [2:0] REQ_TRIG  = 3'd3;
    localparam logic [2:0] REQ_TICK  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CRD,
        ST_CWR,
        ST_T_RD,
        ST_T_S1,
        ST_T_S2,
        ST_T_MUL,
        ST_T_GAIN,
        ST_T_ACC,
        ST_T_OUT
    } spm_state_t;

    // strobes from the sequencer into the voice datapath
    typedef struct packed {
        logic acc_clr;
        logic s1_en;
        logic mul_en;
        logic gain_en;
        logic acc_en;
    } spm_vctl_t;

endpackage

/* design/spm_ram.sv */
// ----------------------------------------------------------------------------
// spm_ram
// single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module spm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr,
    input  logic [WIDTH-1:0]                              wdata,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/spm_voice.sv */
// ----------------------------------------------------------------------------
// spm_voice
// interpolation, gain scaling and mix accumulation for one channel at a time
// ----------------------------------------------------------------------------
module spm_voice
    import spm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  spm_vctl_t    vctl,
    input  logic [15:0]  word,
    input  logic [31:0]  frac,
    input  logic [11:0]  gain,
    output logic [15:0]  acc
);

    logic signed [15:0] s1_reg;
    logic signed [49:0] prod_reg;
    logic signed [49:0] prod_next;
    logic signed [28:0] scaled_reg;
    logic signed [28:0] scaled_next;
    logic        [15:0] acc_reg;
    logic        [15:0] acc_next;
    logic signed [16:0] diff;
    logic signed [17:0] interp;

    always_comb
    begin
        diff = $signed({word[15], word}) - $signed({s1_reg[15], s1_reg});
        prod_next = diff * $signed({1'b0, frac});
        // floor of product / 2^32 is its top bits
        interp = $signed({{2{s1_reg[15]}}, s1_reg}) + $signed(prod_reg[49:32]);
        scaled_next = $signed(interp[15:0]) * $signed({1'b0, gain});
        acc_next = acc_reg + scaled_reg[27:12];
    end

    always_ff @(posedge clk)
    begin
        if (vctl.s1_en)
        begin
            s1_reg <= $signed(word);
        end
        if (vctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (vctl.gain_en)
        begin
            scaled_reg <= scaled_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (vctl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (vctl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* design/sample_playback_mixer_unit.sv */
// ----------------------------------------------------------------------------
// sample_playback_mixer_unit
// multi-channel sample playback with linear interpolation and 16-bit mix
// load: store write; length, speed, trigger: read, modify, write
// tick: reads the channel table entry of every channel and, per playing voice,
//   two sample store words before the result strobe
// busy stays high through the result strobe, next beat taken in the cycle after it
// reset clears channel table valid flags (table reads as zero); the sample
//   store is not cleared and holds no value until written
// ----------------------------------------------------------------------------
module sample_playback_mixer_unit
    import spm_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int STORE_WORDS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic [2:0]         channel_index,
    input  logic [15:0]        sample_address,
    input  logic signed [15:0] sample_word,
    input  logic [16:0]        length_words,
    input  logic signed [39:0] speed_step,
    input  logic [11:0]        hit_velocity,
    output logic               result_valid,
    output logic signed [15:0] mixed_sample
);

    localparam int AW      = $clog2(STORE_WORDS);
    localparam int CW      = AW + 1;
    localparam int CHW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SDEPTH  = CHANNELS * STORE_WORDS;
    localparam int SAW     = $clog2(SDEPTH);
    localparam int GAIN_LSB = 0;
    localparam int CNT_LSB  = 12;
    localparam int SPD_LSB  = CNT_LSB + CW;
    localparam int POS_LSB  = SPD_LSB + 40;
    localparam int EW       = POS_LSB + 64;

    spm_state_t state_reg;
    spm_state_t state_next;

    logic [2:0]     req_type_reg;
    logic [CHW-1:0] req_ch_reg;
    logic [AW-1:0]  req_addr_reg;
    logic [15:0]    req_word_reg;
    logic [CW-1:0]  req_len_reg;
    logic [39:0]    req_speed_reg;
    logic [11:0]    req_vel_reg;

    logic [CHW-1:0] ch_cnt_reg;
    logic [CHW-1:0] ch_cnt_next;
    logic [EW-1:0]  entry_reg;
    logic [AW-1:0]  toward_reg;
    logic [CHANNELS-1:0] valid_reg;
    logic           vld_rd_reg;

    logic           accept;
    logic           ch_ok;
    logic [CW-1:0]  len_sat;
    logic           last_ch;

    logic           ch_we;
    logic [CHW-1:0] ch_addr;
    logic [EW-1:0]  ch_wdata;
    logic [EW-1:0]  ch_rdata;
    logic [EW-1:0]  entry_eff;
    logic           st_we;
    logic [SAW-1:0] st_addr;
    logic [15:0]    st_rdata;
    spm_vctl_t      vctl;

    // fields of the entry just read
    logic [63:0]    e_pos;
    logic [39:0]    e_spd;
    logic [CW-1:0]  e_cnt;
    logic [31:0]    t_hi;
    logic [31:0]    t_hi_p1;
    logic [31:0]    t_cnt32;
    logic           t_fwd;
    logic           t_play;
    logic [AW-1:0]  t_toward;
    logic [EW-1:0]  cfg_entry;
    logic [EW-1:0]  wb_entry;
    logic [63:0]    wb_pos;

    assign accept  = start && (state_reg == ST_IDLE);
    assign ch_ok   = (32'(channel_index) < CHANNELS);
    assign len_sat = (32'(length_words) > STORE_WORDS) ? CW'(STORE_WORDS)
                                                        : CW'(length_words);
    assign last_ch = (ch_cnt_reg == CHW'(CHANNELS - 1));

    // ---------------- channel table ----------------
    spm_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNELS)
    ) u_chan_ram (
        .clk   (clk),
        .we    (ch_we),
        .addr  (ch_addr),
        .wdata (ch_wdata),
        .rdata (ch_rdata)
    );

    // ---------------- sample store ----------------
    spm_ram #(
        .WIDTH (16),
        .DEPTH (SDEPTH)
    ) u_store_ram (
        .clk   (clk),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (req_word_reg),
        .rdata (st_rdata)
    );

    spm_voice u_voice (
        .clk   (clk),
        .rst_n (rst_n),
        .vctl  (vctl),
        .word  (st_rdata),
        .frac  (entry_reg[POS_LSB +: 32]),
        .gain  (entry_reg[GAIN_LSB +: 12]),
        .acc   (mixed_sample)
    );

    // ---------------- entry decode ----------------
    always_comb
    begin
        entry_eff = vld_rd_reg ? ch_rdata : '0;
        e_pos     = entry_eff[POS_LSB +: 64];
        e_spd     = entry_eff[SPD_LSB +: 40];
        e_cnt     = entry_eff[CNT_LSB +: CW];
        t_hi      = e_pos[63:32];
        t_hi_p1   = t_hi + 32'd1;
        t_cnt32   = 32'(e_cnt);
        t_fwd     = !e_spd[39] && (e_spd != '0);
        if (t_fwd)
        begin
            t_play   = !t_hi[31] && (t_hi < t_cnt32);
            // last word plays flat
            t_toward = (t_hi_p1 < t_cnt32) ? t_hi_p1[AW-1:0] : t_hi[AW-1:0];
        end
        else
        begin
            t_play   = !t_hi[31] && (t_hi != 32'd0);
            t_toward = AW'(t_hi - 32'd1);
        end
    end

    // configuration update of one entry
    always_comb
    begin
        cfg_entry = entry_eff;
        case (req_type_reg)
            REQ_LEN:
            begin
                cfg_entry[CNT_LSB +: CW] = req_len_reg;
            end
            REQ_SPEED:
            begin
                cfg_entry[SPD_LSB +: 40] = req_speed_reg;
            end
            REQ_TRIG:
            begin
                cfg_entry[GAIN_LSB +: 12] = req_vel_reg;
                if (t_fwd || (e_cnt == '0))
                begin
                    cfg_entry[POS_LSB +: 64] = '0;
                end
                else
                begin
                    cfg_entry[POS_LSB +: 64] = {32'(e_cnt - CW'(1)), 32'd0};
                end
            end
            default:
            begin
                cfg_entry = entry_eff;
            end
        endcase
    end

    always_comb
    begin
        wb_pos   = entry_reg[POS_LSB +: 64]
                 + {{24{entry_reg[SPD_LSB + 39]}}, entry_reg[SPD_LSB +: 40]};
        wb_entry = entry_reg;
        wb_entry[POS_LSB +: 64] = wb_pos;
    end

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next  = state_reg;
        ch_cnt_next = ch_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_LOAD:
                        begin
                            state_next = ch_ok ? ST_LOAD : ST_IDLE;
                        end
                        REQ_LEN, REQ_SPEED, REQ_TRIG:
                        begin
                            state_next = ch_ok ? ST_CRD : ST_IDLE;
                        end
                        REQ_TICK:
                        begin
                            state_next  = ST_T_RD;
                            ch_cnt_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD:   state_next = ST_IDLE;
            ST_CRD:    state_next = ST_CWR;
            ST_CWR:    state_next = ST_IDLE;
            ST_T_RD:   state_next = ST_T_S1;
            ST_T_S1:
            begin
                if (t_play)
                begin
                    state_next = ST_T_S2;
                end
                else if (last_ch)
                begin
                    state_next = ST_T_OUT;
                end
                else
                begin
                    state_next  = ST_T_RD;
                    ch_cnt_next = ch_cnt_reg + CHW'(1);
                end
            end
            ST_T_S2:   state_next = ST_T_MUL;
            ST_T_MUL:  state_next = ST_T_GAIN;
            ST_T_GAIN: state_next = ST_T_ACC;
            ST_T_ACC:
            begin
                if (last_ch)
                begin
                    state_next = ST_T_OUT;
                end
                else
                begin
                    state_next  = ST_T_RD;
                    ch_cnt_next = ch_cnt_reg + CHW'(1);
                end
            end
            ST_T_OUT:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        result_valid = 1'b0;
        ch_we        = 1'b0;
        ch_addr      = req_ch_reg;
        ch_wdata     = cfg_entry;
        st_we        = 1'b0;
        st_addr      = SAW'({req_ch_reg, req_addr_reg});
        vctl         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                vctl.acc_clr = start && (req_type == REQ_TICK);
            end
            ST_LOAD:
            begin
                st_we = 1'b1;
            end
            ST_CWR:
            begin
                ch_we = 1'b1;
            end
            ST_T_RD:
            begin
                ch_addr = ch_cnt_reg;
            end
            ST_T_S1:
            begin
                ch_addr = ch_cnt_reg;
                st_addr = SAW'({ch_cnt_reg, t_hi[AW-1:0]});
            end
            ST_T_S2:
            begin
                ch_addr    = ch_cnt_reg;
                st_addr    = SAW'({ch_cnt_reg, toward_reg});
                vctl.s1_en = 1'b1;
            end
            ST_T_MUL:
            begin
                ch_addr     = ch_cnt_reg;
                vctl.mul_en = 1'b1;
            end
            ST_T_GAIN:
            begin
                ch_addr      = ch_cnt_reg;
                vctl.gain_en = 1'b1;
            end
            ST_T_ACC:
            begin
                ch_addr     = ch_cnt_reg;
                ch_we       = 1'b1;
                ch_wdata    = wb_entry;
                vctl.acc_en = 1'b1;
            end
            ST_T_OUT:
            begin
                result_valid = 1'b1;
            end
            default:
            begin
                result_valid = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ch_cnt_reg <= '0;
            valid_reg  <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ch_cnt_reg <= ch_cnt_next;
            vld_rd_reg <= valid_reg[ch_addr];
            if (ch_we)
            begin
                valid_reg[ch_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg  <= req_type;
            req_ch_reg    <= CHW'(channel_index);
            req_addr_reg  <= AW'(sample_address);
            req_word_reg  <= sample_word;
            req_len_reg   <= len_sat;
            req_speed_reg <= speed_step;
            req_vel_reg   <= hit_velocity;
        end
        if (state_reg == ST_T_S1)
        begin
            entry_reg  <= entry_eff;
            toward_reg <= t_toward;
        end
    end

    // ---------------- checks ----------------
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_TICK)) |=> busy)
        else $error("tick beat did not start a mix pass");

    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        ch_we |-> (32'(ch_addr) < CHANNELS))
        else $error("channel table write outside channel range");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |=> !busy)
        else $error("sample load did not return to idle");

endmodule

/* tb/sample_playback_mixer_checker.sv */
// ----------------------------------------------------------------------------
// sample_playback_mixer_checker
// watches the command and result channels of the playback mixer, keeps its own
// copy of the channel state, predicts each tick's mix and compares it
// ----------------------------------------------------------------------------
module sample_playback_mixer_checker
    import spm_pkg::*;
#(
    parameter int CHANNELS    = 8,
    parameter int STORE_WORDS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         req_type,
    input  logic [2:0]         channel_index,
    input  logic [15:0]        sample_address,
    input  logic signed [15:0] sample_word,
    input  logic [16:0]        length_words,
    input  logic signed [39:0] speed_step,
    input  logic [11:0]        hit_velocity,
    input  logic               result_valid,
    input  logic signed [15:0] mixed_sample,
    output int                 pending,
    output int                 fails
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]        words [int unsigned];
    logic [63:0]        pos [CHANNELS];
    logic signed [39:0] spd [CHANNELS];
    logic [16:0]        cnt [CHANNELS];
    logic [11:0]        vel [CHANNELS];
    logic [15:0]        mix_q [$];
    int                 miss_count = 0;

    function automatic logic moving_fwd(input logic signed [39:0] s);
        return !s[39] && s != 0;
    endfunction

    function automatic int stored_word(input int c, input logic [31:0] idx);
        int unsigned key;
        key = c * STORE_WORDS + (idx % STORE_WORDS);
        if (!words.exists(key))
            return 0;
        return int'(signed'(words[key]));
    endfunction

    // s1 + floor((s2 - s1) * frac / 2^32)
    function automatic int lerp_word(input int c, input logic [31:0] from_idx,
                                     input logic [31:0] to_idx, input logic [31:0] fr);
        int     s1;
        int     s2;
        longint d;
        s1 = stored_word(c, from_idx);
        s2 = stored_word(c, to_idx);
        d  = longint'(s2 - s1) * longint'({32'd0, fr});
        return s1 + int'(d >>> 32);
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        logic [15:0] sum;
        logic [15:0] want;
        logic [31:0] ip;
        logic [31:0] fr;
        logic        fwd;
        logic        live;
        int          s;
        int          ch;
        if (!rst_n) begin
            words.delete();
            mix_q.delete();
            for (int c = 0; c < CHANNELS; c++) begin
                pos[c] = '0;
                spd[c] = '0;
                cnt[c] = '0;
                vel[c] = '0;
            end
            pending <= 0;
        end
        else begin
            if (result_valid) begin
                if (mix_q.size() == 0) begin
                    if (miss_count < 10)
                        $display("unexpected mixed_sample %0d with nothing expected",
                                 mixed_sample);
                    miss_count++;
                end
                else begin
                    want = mix_q.pop_front();
                    if (want !== mixed_sample) begin
                        if (miss_count < 10)
                            $display("mixed_sample mismatch: expected %0d, got %0d",
                                     $signed(want), mixed_sample);
                        miss_count++;
                    end
                end
            end

            if (start && !busy) begin
                ch = int'(channel_index);
                if (req_type == REQ_TICK) begin
                    sum = '0;
                    for (int c = 0; c < CHANNELS; c++) begin
                        ip  = pos[c][63:32];
                        fr  = pos[c][31:0];
                        fwd = moving_fwd(spd[c]);
                        // negative integer part never plays, either direction
                        if (fwd)
                            live = !ip[31] && ip < 32'(cnt[c]);
                        else
                            live = !ip[31] && ip != 32'd0;
                        if (live) begin
                            if (!fwd)
                                s = lerp_word(c, ip, ip - 32'd1, fr);
                            else if (ip + 32'd1 < 32'(cnt[c]))
                                s = lerp_word(c, ip, ip + 32'd1, fr);
                            else
                                s = stored_word(c, ip);
                            sum += 16'((s * int'(vel[c])) >>> 12);
                            pos[c] += {{24{spd[c][39]}}, spd[c]};
                        end
                    end
                    mix_q.push_back(sum);
                end
                else if (ch < CHANNELS) begin
                    case (req_type)
                        REQ_LOAD:
                            words[ch * STORE_WORDS + (sample_address % STORE_WORDS)] =
                                sample_word;
                        REQ_LEN:
                            cnt[ch] = (length_words > STORE_WORDS) ?
                                      17'(STORE_WORDS) : length_words;
                        REQ_SPEED:
                            spd[ch] = speed_step;
                        REQ_TRIG:
                        begin
                            vel[ch] = hit_velocity;
                            if (moving_fwd(spd[ch]) || cnt[ch] == '0)
                                pos[ch] = '0;
                            else
                                pos[ch] = {15'd0, cnt[ch] - 17'd1, 32'd0};
                        end
                        default: ;
                    endcase
                end
            end
            pending <= mix_q.size();
        end
        fails <= miss_count;
    end

endmodule

/* tb/sample_playback_mixer_unit_test.sv */
// ----------------------------------------------------------------------------
// sample_playback_mixer_unit_test
// drives load, length, speed, trigger, tick and unused request codes into the
// playback mixer with random idle gaps, keeps every read inside written sample
// words, and reports the verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module sample_playback_mixer_unit_test
    import spm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS    = 8;
    localparam int STORE_WORDS = 65536;
    localparam int FILL_WORDS  = 16;
    localparam int ITEMS       = 1050;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic [2:0]         req_type       = '0;
    logic [2:0]         channel_index  = '0;
    logic [15:0]        sample_address = '0;
    logic signed [15:0] sample_word    = '0;
    logic [16:0]        length_words   = '0;
    logic signed [39:0] speed_step     = '0;
    logic [11:0]        hit_velocity   = '0;
    logic               result_valid;
    logic signed [15:0] mixed_sample;
    int                 pending;
    int                 fails;
    int                 items      = 0;
    int                 burst_left = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sample_playback_mixer_unit #(
        .CHANNELS    (CHANNELS),
        .STORE_WORDS (STORE_WORDS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .channel_index  (channel_index),
        .sample_address (sample_address),
        .sample_word    (sample_word),
        .length_words   (length_words),
        .speed_step     (speed_step),
        .hit_velocity   (hit_velocity),
        .result_valid   (result_valid),
        .mixed_sample   (mixed_sample)
    );

    sample_playback_mixer_checker #(
        .CHANNELS    (CHANNELS),
        .STORE_WORDS (STORE_WORDS)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .channel_index  (channel_index),
        .sample_address (sample_address),
        .sample_word    (sample_word),
        .length_words   (length_words),
        .speed_step     (speed_step),
        .hit_velocity   (hit_velocity),
        .result_valid   (result_valid),
        .mixed_sample   (mixed_sample),
        .pending        (pending),
        .fails          (fails)
    );

    function automatic int idle_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [39:0] rnd40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // mostly slow speeds so voices last a few ticks, now and then any value
    function automatic logic [39:0] pick_speed();
        logic [39:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = rnd40();
            default: v = {6'd0, 2'($urandom_range(0, 2)), 32'($urandom)};
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // start stays high across back-to-back beats
    task automatic issue(input logic [2:0] req, input logic [2:0] ch,
                         input logic [15:0] addr, input logic [15:0] w,
                         input logic [16:0] len, input logic [39:0] step,
                         input logic [11:0] v);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        req_type       <= req;
        channel_index  <= ch;
        sample_address <= addr;
        sample_word    <= w;
        length_words   <= len;
        speed_step     <= step;
        hit_velocity   <= v;
        do @(posedge clk); while (busy);
        if (req <= REQ_TICK)
            items++;
    endtask

    task automatic load_word(input int c, input int a, input int w);
        issue(REQ_LOAD, 3'(c), 16'(a), 16'(w), 17'($urandom), rnd40(), 12'($urandom));
    endtask

    task automatic set_length(input int c, input int len);
        issue(REQ_LEN, 3'(c), 16'($urandom), 16'($urandom), 17'(len), rnd40(),
              12'($urandom));
    endtask

    task automatic set_speed(input int c, input logic [39:0] step);
        issue(REQ_SPEED, 3'(c), 16'($urandom), 16'($urandom), 17'($urandom), step,
              12'($urandom));
    endtask

    task automatic hit(input int c, input int v);
        issue(REQ_TRIG, 3'(c), 16'($urandom), 16'($urandom), 17'($urandom), rnd40(),
              12'(v));
    endtask

    task automatic mix_tick();
        issue(REQ_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 17'($urandom),
              rnd40(), 12'($urandom));
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin : stimulus
        int  r;
        int  c;
        logic paused;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // forward at half speed: interpolation, then last word held
        load_word(1, 0, 16'sh7FFF);
        load_word(1, 1, 16'sh8000);
        load_word(1, 16'hFFFF, 16'sh3039);
        load_word(1, 16'hFFFE, 16'shFFFF);
        set_length(1, 2);
        set_speed(1, 40'sh00_8000_0000);
        hit(1, 12'hFFF);
        repeat (4) mix_tick();
        // oversized length saturates, full reverse step from the top word
        set_length(1, 17'h1FFFF);
        set_speed(1, 40'sh80_0000_0000);
        hit(1, 12'hFFF);
        mix_tick();
        // park the voice: empty length puts the position at zero
        set_length(1, 0);
        hit(1, 12'h000);
        // zero speed repeats one word for good
        load_word(2, 0, -1234);
        load_word(2, 1, 5000);
        set_length(2, 2);
        set_speed(2, '0);
        hit(2, 12'h800);
        mix_tick();
        // fastest forward speed on an empty voice, then an unused request code
        set_speed(3, 40'sh7F_FFFF_FFFF);
        hit(3, 12'hFFF);
        issue(REQ_TICK + 3'd3, 3'($urandom), 16'($urandom), 16'($urandom),
              17'($urandom), rnd40(), 12'($urandom));

        // every voice reads only inside this window from here on
        for (int ch = 0; ch < CHANNELS; ch++)
            for (int a = 0; a < FILL_WORDS; a++)
                load_word(ch, a, $urandom);

        while (items < ITEMS)
        begin
            if (!paused && items >= ITEMS / 2)
            begin
                drain();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            c = $urandom_range(0, CHANNELS - 1);
            if (r < 40)
                mix_tick();
            else if (r < 55)
            begin
                if ($urandom_range(0, 19) == 0)
                    load_word(c, $urandom_range(0, 65535), $urandom);
                else
                    load_word(c, $urandom_range(0, FILL_WORDS - 1), $urandom);
            end
            else if (r < 65)
            begin
                // an oversized length is always replaced before the next tick
                if ($urandom_range(0, 7) == 0)
                    set_length(c, $urandom_range(0, 17'h1FFFF));
                set_length(c, $urandom_range(0, FILL_WORDS));
            end
            else if (r < 83)
            begin
                // new speed is always followed by a retrigger to stay in the window
                set_speed(c, pick_speed());
                hit(c, $urandom);
            end
            else if (r < 95)
                hit(c, $urandom);
            else
                issue(REQ_TICK + 3'($urandom_range(1, 3)), 3'($urandom),
                      16'($urandom), 16'($urandom), 17'($urandom), rnd40(),
                      12'($urandom));
        end

        drain();
        repeat (60) @(posedge clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
